// File: design/ekd_pkg.sv
package ekd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 9;
  localparam int unsigned PosW  = 10;

  // configuration register indexes
  localparam logic CFG_SCREEN_ROWS = 1'b0;
  localparam logic CFG_SCREEN_COLS = 1'b1;

  localparam logic [PosW-1:0] SCREEN_ROWS_RST = PosW'(24);
  localparam logic [PosW-1:0] SCREEN_COLS_RST = PosW'(80);

  // bytes of interest
  localparam logic [ByteW-1:0] BYTE_ESC   = 8'h1b;
  localparam logic [ByteW-1:0] BYTE_CSI   = 8'h5b;  // '['
  localparam logic [ByteW-1:0] BYTE_SS3   = 8'h4f;  // 'O'
  localparam logic [ByteW-1:0] BYTE_TILDE = 8'h7e;  // '~'
  localparam logic [ByteW-1:0] BYTE_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] BYTE_NINE  = 8'h39;
  localparam logic [ByteW-1:0] CTRL_MASK  = 8'h1f;
  localparam logic [ByteW-1:0] BYTE_QUIT  = 8'h71 & CTRL_MASK;

  // key codes
  localparam logic [KeyW-1:0] KEY_ESC   = KeyW'(BYTE_ESC);
  localparam logic [KeyW-1:0] KEY_QUIT  = KeyW'(BYTE_QUIT);
  localparam logic [KeyW-1:0] KEY_LEFT  = 9'd256;
  localparam logic [KeyW-1:0] KEY_RIGHT = 9'd257;
  localparam logic [KeyW-1:0] KEY_UP    = 9'd258;
  localparam logic [KeyW-1:0] KEY_DOWN  = 9'd259;
  localparam logic [KeyW-1:0] KEY_DEL   = 9'd260;
  localparam logic [KeyW-1:0] KEY_HOME  = 9'd261;
  localparam logic [KeyW-1:0] KEY_END   = 9'd262;
  localparam logic [KeyW-1:0] KEY_PGUP  = 9'd263;
  localparam logic [KeyW-1:0] KEY_PGDN  = 9'd264;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_SEQ0,
    PH_DIGIT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_CSI,
    KIND_SS3
  } kind_e;

  function automatic logic [KeyW-1:0] csi_letter(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    unique case (b)
      8'h41:   k = KEY_UP;     // 'A'
      8'h42:   k = KEY_DOWN;   // 'B'
      8'h43:   k = KEY_RIGHT;  // 'C'
      8'h44:   k = KEY_LEFT;   // 'D'
      8'h48:   k = KEY_HOME;   // 'H'
      8'h46:   k = KEY_END;    // 'F'
      default: k = KEY_ESC;
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] csi_digit(input logic [ByteW-1:0] d);
    logic [KeyW-1:0] k;
    unique case (d)
      8'h31:   k = KEY_HOME;
      8'h33:   k = KEY_DEL;
      8'h34:   k = KEY_END;
      8'h35:   k = KEY_PGUP;
      8'h36:   k = KEY_PGDN;
      8'h37:   k = KEY_HOME;
      8'h38:   k = KEY_END;
      default: k = KEY_ESC;
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] ss3_letter(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    unique case (b)
      8'h48:   k = KEY_HOME;
      8'h46:   k = KEY_END;
      default: k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage

// File: design/escape_key_decoder_cursor.sv
// Terminal key decoder: each input transfer carries one received byte or a
// timeout tick. Plain bytes come out as their own key code; ESC [ letter,
// ESC [ digit ~ and ESC O letter come out as arrow, Home, End, Delete, Page
// Up and Page Down codes (256..264), and any unknown, broken or timed-out
// sequence comes out as a plain ESC (27). ESC and the bytes inside a
// sequence give no output transfer, nor does a tick while idle. Each output
// transfer also carries the cursor after the key, which moves keep inside
// screen_rows x screen_cols unless the screen shrinks under it, and a quit
// flag for Ctrl-Q. The block takes one input transfer per clock while
// out_ready_i stays high; a byte sits in the input register, is decoded
// against the parser and cursor state and lands in the result register,
// from which the key is offered at the output.
// The input register is freed in the same cycle the result register is
// taken, so full rate holds as long as out_ready_i stays high. Write the
// screen size (index 0 rows, index 1 columns) only while no key is in flight.
module escape_key_decoder_cursor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ekd_pkg::PosW-1:0]     cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ekd_pkg::ByteW-1:0]    in_byte_i,
  input  logic                         timeout_tick_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ekd_pkg::KeyW-1:0]     key_code_o,
  output logic [ekd_pkg::PosW-1:0]     cursor_col_o,
  output logic [ekd_pkg::PosW-1:0]     cursor_row_o,
  output logic                         quit_o
);

  // screen size registers
  logic [ekd_pkg::PosW-1:0] rows_q, cols_q;

  // input register
  logic                      in_vld_q;
  logic [ekd_pkg::ByteW-1:0] byte_q;
  logic                      tick_q;

  // parser and cursor state
  ekd_pkg::phase_e           phase_q, phase_d;
  ekd_pkg::kind_e            kind_q, kind_d;
  logic [ekd_pkg::ByteW-1:0] digit_q, digit_d;
  logic [ekd_pkg::PosW-1:0]  col_q, col_d;
  logic [ekd_pkg::PosW-1:0]  row_q, row_d;

  // result register
  logic                      out_vld_q;
  logic [ekd_pkg::KeyW-1:0]  key_q;
  logic [ekd_pkg::PosW-1:0]  ocol_q, orow_q;
  logic                      quit_q;

  logic                      has_key;   // this byte finishes a key
  logic [ekd_pkg::KeyW-1:0]  key;
  logic                      out_free;
  logic                      s1_go;     // input register is consumed
  logic                      is_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ekd_pkg::SCREEN_ROWS_RST;
      cols_q <= ekd_pkg::SCREEN_COLS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ekd_pkg::CFG_SCREEN_ROWS) begin
        rows_q <= cfg_data_i;
      end else begin
        cols_q <= cfg_data_i;
      end
    end
  end

  // handshake: the input register frees up when its byte is decoded, and a
  // byte that finishes a key waits until the result register has room
  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_go      = in_vld_q && (!has_key || out_free);
  assign in_ready_o = !in_vld_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      tick_q <= timeout_tick_i;
    end
  end

  assign is_digit = (byte_q >= ekd_pkg::BYTE_ZERO) && (byte_q <= ekd_pkg::BYTE_NINE);

  // sequence parser
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    digit_d = digit_q;
    has_key = 1'b0;
    key     = ekd_pkg::KEY_ESC;
    if (tick_q) begin
      // a timeout aborts any open sequence as a bare ESC
      has_key = (phase_q != ekd_pkg::PH_IDLE);
    end else begin
      unique case (phase_q)
        ekd_pkg::PH_IDLE: begin
          if (byte_q == ekd_pkg::BYTE_ESC) begin
            phase_d = ekd_pkg::PH_ESC;
          end else begin
            has_key = 1'b1;
            key     = ekd_pkg::KeyW'(byte_q);
          end
        end
        ekd_pkg::PH_ESC: begin
          phase_d = ekd_pkg::PH_SEQ0;
          priority if (byte_q == ekd_pkg::BYTE_CSI) begin
            kind_d = ekd_pkg::KIND_CSI;
          end else if (byte_q == ekd_pkg::BYTE_SS3) begin
            kind_d = ekd_pkg::KIND_SS3;
          end else begin
            kind_d = ekd_pkg::KIND_OTHER;
          end
        end
        ekd_pkg::PH_SEQ0: begin
          if (kind_q == ekd_pkg::KIND_CSI && is_digit) begin
            phase_d = ekd_pkg::PH_DIGIT;
            digit_d = byte_q;
          end else begin
            has_key = 1'b1;
            unique case (kind_q)
              ekd_pkg::KIND_CSI: key = ekd_pkg::csi_letter(byte_q);
              ekd_pkg::KIND_SS3: key = ekd_pkg::ss3_letter(byte_q);
              default:           key = ekd_pkg::KEY_ESC;
            endcase
          end
        end
        default: begin
          has_key = 1'b1;
          key     = (byte_q == ekd_pkg::BYTE_TILDE) ? ekd_pkg::csi_digit(digit_q)
                                                    : ekd_pkg::KEY_ESC;
        end
      endcase
    end
    if (has_key) begin
      phase_d = ekd_pkg::PH_IDLE;
      kind_d  = ekd_pkg::KIND_OTHER;
      digit_d = '0;
    end
  end

  // cursor update; moves away from zero only while position + 1 < size
  logic row_can_inc, col_can_inc;
  assign row_can_inc = ({1'b0, row_q} + 11'd1) < {1'b0, rows_q};
  assign col_can_inc = ({1'b0, col_q} + 11'd1) < {1'b0, cols_q};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    unique case (key)
      ekd_pkg::KEY_UP:    if (row_q != '0) row_d = row_q - 10'd1;
      ekd_pkg::KEY_DOWN:  if (row_can_inc) row_d = row_q + 10'd1;
      ekd_pkg::KEY_LEFT:  if (col_q != '0) col_d = col_q - 10'd1;
      ekd_pkg::KEY_RIGHT: if (col_can_inc) col_d = col_q + 10'd1;
      ekd_pkg::KEY_HOME:  col_d = '0;
      ekd_pkg::KEY_END:   col_d = (cols_q != '0) ? cols_q - 10'd1 : '0;
      ekd_pkg::KEY_PGUP:  row_d = (row_q >= rows_q) ? row_q - rows_q : '0;
      // a page down moves to the last row whenever the cursor is above it
      ekd_pkg::KEY_PGDN:  if (row_can_inc) row_d = rows_q - 10'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ekd_pkg::PH_IDLE;
      kind_q  <= ekd_pkg::KIND_OTHER;
      digit_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (s1_go) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      digit_q <= digit_d;
      if (has_key) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_go && has_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && has_key) begin
      key_q  <= key;
      ocol_q <= col_d;
      orow_q <= row_d;
      quit_q <= (key == ekd_pkg::KEY_QUIT);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign key_code_o   = key_q;
  assign cursor_col_o = ocol_q;
  assign cursor_row_o = orow_q;
  assign quit_o       = quit_q;

`ifndef SYNTHESIS
  a_quit_only_ctrl_q : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (quit_q == (key_q == ekd_pkg::KEY_QUIT)))
    else $error("quit flag disagrees with key code");

  a_key_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (key_q <= ekd_pkg::KEY_PGDN))
    else $error("key code out of range");

  a_esc_opens_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && !tick_q && phase_q == ekd_pkg::PH_IDLE && byte_q == ekd_pkg::BYTE_ESC)
    |=> (phase_q == ekd_pkg::PH_ESC))
    else $error("ESC did not open a sequence");

  a_no_key_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ready_i && !(s1_go && has_key)) |=> !out_vld_q)
    else $error("result appeared without a finished key");

  a_key_resets_parser : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && has_key) |=> (phase_q == ekd_pkg::PH_IDLE && digit_q == '0))
    else $error("parser not back to idle after a key");
`endif

endmodule

// File: test/escape_key_decoder_cursor_checker.sv
`timescale 1ns / 1ps

module escape_key_decoder_cursor_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [ekd_pkg::PosW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [ekd_pkg::ByteW-1:0] in_byte_i,
  input  logic                     timeout_tick_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [ekd_pkg::KeyW-1:0] key_code_i,
  input  logic [ekd_pkg::PosW-1:0] cursor_col_i,
  input  logic [ekd_pkg::PosW-1:0] cursor_row_i,
  input  logic                     quit_i,
  output int                       err_cnt_o,
  output int                       keys_waiting_o,
  output int                       keys_checked_o
);
  import ekd_pkg::*;

  // final letters of the escape sequences
  localparam logic [ByteW-1:0] LTR_UP    = 8'h41;
  localparam logic [ByteW-1:0] LTR_DOWN  = 8'h42;
  localparam logic [ByteW-1:0] LTR_RIGHT = 8'h43;
  localparam logic [ByteW-1:0] LTR_LEFT  = 8'h44;
  localparam logic [ByteW-1:0] LTR_END   = 8'h46;
  localparam logic [ByteW-1:0] LTR_HOME  = 8'h48;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic            quit;
  } key_result_t;

  key_result_t     expected_keys[$];
  key_result_t     got_key;
  key_result_t     want_key;

  phase_e          parse_ph;
  kind_e           esc_kind;
  logic [ByteW-1:0] csi_digit_byte;
  logic [PosW-1:0] cur_col;
  logic [PosW-1:0] cur_row;
  logic [PosW-1:0] scr_rows;
  logic [PosW-1:0] scr_cols;
  int              errs;
  int              checked;

  function automatic logic [KeyW-1:0] csi_final_key(input logic [ByteW-1:0] b);
    case (b)
      LTR_UP:    return KEY_UP;
      LTR_DOWN:  return KEY_DOWN;
      LTR_RIGHT: return KEY_RIGHT;
      LTR_LEFT:  return KEY_LEFT;
      LTR_HOME:  return KEY_HOME;
      LTR_END:   return KEY_END;
      default:   return KEY_ESC;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] tilde_key(input logic [ByteW-1:0] d);
    case (d)
      8'h31:   return KEY_HOME;  // '1'
      8'h33:   return KEY_DEL;   // '3'
      8'h34:   return KEY_END;   // '4'
      8'h35:   return KEY_PGUP;  // '5'
      8'h36:   return KEY_PGDN;  // '6'
      8'h37:   return KEY_HOME;  // '7'
      8'h38:   return KEY_END;   // '8'
      default: return KEY_ESC;
    endcase
  endfunction

  task automatic move_cursor(input logic [KeyW-1:0] key);
    int r;
    int c;
    int nr;
    int nc;
    r  = int'(cur_row);
    c  = int'(cur_col);
    nr = int'(scr_rows);
    nc = int'(scr_cols);
    case (key)
      KEY_UP:    if (r > 0) r--;
      KEY_DOWN:  if (r + 1 < nr) r++;
      KEY_LEFT:  if (c > 0) c--;
      KEY_RIGHT: if (c + 1 < nc) c++;
      KEY_HOME:  c = 0;
      KEY_END:   c = (nc > 0) ? nc - 1 : 0;
      KEY_PGUP:  r = (r >= nr) ? r - nr : 0;
      KEY_PGDN: begin
        if (r + 1 < nr) begin
          r = r + nr;
          if (r > nr - 1) r = nr - 1;
        end
      end
      default: ;
    endcase
    cur_col = c[PosW-1:0];
    cur_row = r[PosW-1:0];
  endtask

  task automatic decode_term_byte(input logic [ByteW-1:0] b, input logic tick);
    logic [KeyW-1:0] key;
    bit              done;
    key  = KEY_ESC;
    done = 1'b0;
    if (tick) begin
      if (parse_ph != PH_IDLE) done = 1'b1;
    end else begin
      case (parse_ph)
        PH_IDLE: begin
          if (b == BYTE_ESC) parse_ph = PH_ESC;
          else begin
            key  = {1'b0, b};
            done = 1'b1;
          end
        end
        PH_ESC: begin
          esc_kind = (b == BYTE_CSI) ? KIND_CSI : (b == BYTE_SS3) ? KIND_SS3 : KIND_OTHER;
          parse_ph = PH_SEQ0;
        end
        PH_SEQ0: begin
          if (esc_kind == KIND_CSI && b >= BYTE_ZERO && b <= BYTE_NINE) begin
            csi_digit_byte = b;
            parse_ph       = PH_DIGIT;
          end else begin
            done = 1'b1;
            if (esc_kind == KIND_CSI) key = csi_final_key(b);
            else if (esc_kind == KIND_SS3) begin
              key = (b == LTR_HOME) ? KEY_HOME : (b == LTR_END) ? KEY_END : KEY_ESC;
            end
          end
        end
        default: begin
          done = 1'b1;
          key  = (b == BYTE_TILDE) ? tilde_key(csi_digit_byte) : KEY_ESC;
        end
      endcase
    end
    if (done) begin
      parse_ph       = PH_IDLE;
      esc_kind       = KIND_OTHER;
      csi_digit_byte = '0;
      move_cursor(key);
      expected_keys.push_back('{key, cur_col, cur_row, key == KEY_QUIT});
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_keys.delete();
      parse_ph       = PH_IDLE;
      esc_kind       = KIND_OTHER;
      csi_digit_byte = '0;
      cur_col        = '0;
      cur_row        = '0;
      scr_rows       = SCREEN_ROWS_RST;
      scr_cols       = SCREEN_COLS_RST;
      errs           = 0;
      checked        = 0;
      err_cnt_o      <= 0;
      keys_waiting_o <= 0;
      keys_checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SCREEN_ROWS) scr_rows = cfg_data_i;
        else scr_cols = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        got_key = '{key_code_i, cursor_col_i, cursor_row_i, quit_i};
        if (expected_keys.size() == 0) begin
          errs++;
          $display("%0t: unexpected key, expected none, got key %0d col %0d row %0d",
                   $time, key_code_i, cursor_col_i, cursor_row_i);
        end else begin
          want_key = expected_keys.pop_front();
          check_field("key_code", want_key.key, got_key.key);
          check_field("cursor_col", want_key.col, got_key.col);
          check_field("cursor_row", want_key.row, got_key.row);
          check_field("quit", want_key.quit, got_key.quit);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) decode_term_byte(in_byte_i, timeout_tick_i);
      err_cnt_o      <= errs;
      keys_waiting_o <= expected_keys.size();
      keys_checked_o <= checked;
    end
  end

endmodule

// File: test/escape_key_decoder_cursor_tb.sv
`timescale 1ns / 1ps

module escape_key_decoder_cursor_tb;
  import ekd_pkg::*;

  localparam int ItemsPerPhase = 200;
  localparam int HoldCycles    = 80;    // long receiver hold-off
  localparam int SettleCycles  = 4;     // covers the two-stage pipe with margin
  localparam int WatchdogLimit = 2000;  // cycles with no transfer on either side

  // final letters of the escape sequences
  localparam logic [ByteW-1:0] LTR_UP    = 8'h41;
  localparam logic [ByteW-1:0] LTR_DOWN  = 8'h42;
  localparam logic [ByteW-1:0] LTR_RIGHT = 8'h43;
  localparam logic [ByteW-1:0] LTR_LEFT  = 8'h44;
  localparam logic [ByteW-1:0] LTR_END   = 8'h46;
  localparam logic [ByteW-1:0] LTR_HOME  = 8'h48;
  localparam logic [ByteW-1:0] LTR_JUNK  = 8'h58;  // 'X', not a known sequence byte

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             tick;
  } term_item_t;

  // every block input starts at a known value
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_idx   = CFG_SCREEN_ROWS;
  logic [PosW-1:0]  cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic [ByteW-1:0] in_byte   = '0;
  logic             in_tick   = 1'b0;
  logic             out_ready = 1'b0;

  logic             in_ready;
  logic             out_valid;
  logic [KeyW-1:0]  key_code;
  logic [PosW-1:0]  cursor_col;
  logic [PosW-1:0]  cursor_row;
  logic             quit;

  int               err_cnt;
  int               keys_waiting;
  int               keys_checked;

  int               snd_idle_pct = 0;
  int               rcv_idle_pct = 0;
  int               hold_reqs    = 0;
  int               xfers_sent   = 0;
  int               sizes_used   = 1;
  term_item_t       seq_q[$];

  escape_key_decoder_cursor u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .timeout_tick_i (in_tick),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .key_code_o     (key_code),
    .cursor_col_o   (cursor_col),
    .cursor_row_o   (cursor_row),
    .quit_o         (quit)
  );

  escape_key_decoder_cursor_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_byte_i      (in_byte),
    .timeout_tick_i (in_tick),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .key_code_i     (key_code),
    .cursor_col_i   (cursor_col),
    .cursor_row_i   (cursor_row),
    .quit_i         (quit),
    .err_cnt_o      (err_cnt),
    .keys_waiting_o (keys_waiting),
    .keys_checked_o (keys_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin : ready_gen
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog: ends the run if neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
        $display("escape_key_decoder_cursor_tb: errors");
        $finish;
      end
    end
  end

  // one input transfer; an optional idle gap comes first so valid is never
  // dropped and raised in the same step
  task automatic send_item(input logic [ByteW-1:0] b, input logic tick);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_tick  <= tick;
    do @(posedge clk); while (!in_ready);
    xfers_sent++;
  endtask

  task automatic flush_seq();
    term_item_t it;
    while (seq_q.size() != 0) begin
      it = seq_q.pop_front();
      send_item(it.b, it.tick);
    end
  endtask

  task automatic queue_byte(input logic [ByteW-1:0] b);
    seq_q.push_back('{b, 1'b0});
  endtask

  // a tick carries a random byte that the block must ignore
  task automatic queue_tick();
    seq_q.push_back('{ByteW'($urandom_range(255)), 1'b1});
  endtask

  task automatic queue_esc_seq(input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2);
    queue_byte(BYTE_ESC);
    queue_byte(b1);
    queue_byte(b2);
  endtask

  function automatic logic [ByteW-1:0] rand_csi_letter();
    case ($urandom_range(5))
      0:       return LTR_UP;
      1:       return LTR_DOWN;
      2:       return LTR_RIGHT;
      3:       return LTR_LEFT;
      4:       return LTR_HOME;
      default: return LTR_END;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] rand_digit();
    return BYTE_ZERO + ByteW'($urandom_range(9));
  endfunction

  // builds one key's worth of bytes; idle ticks are not counted
  task automatic make_random_key(output int counted);
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // well-formed sequences with random content
      case ($urandom_range(2))
        0: queue_esc_seq(BYTE_CSI, rand_csi_letter());
        1: queue_esc_seq(BYTE_SS3, $urandom_range(1) ? LTR_HOME : LTR_END);
        default: begin
          queue_esc_seq(BYTE_CSI, rand_digit());
          queue_byte(BYTE_TILDE);
        end
      endcase
    end else if (pick < 60) begin
      queue_byte(ByteW'($urandom_range(255)));
    end else if (pick < 65) begin
      queue_byte(BYTE_QUIT);
    end else if (pick < 80) begin
      // broken sequences
      if ($urandom_range(1)) begin
        queue_esc_seq(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
      end else begin
        queue_esc_seq(BYTE_CSI, rand_digit());
        queue_byte(ByteW'($urandom_range(255)));
      end
    end else if (pick < 90) begin
      // timeout in the middle of a sequence
      queue_byte(BYTE_ESC);
      if ($urandom_range(1)) begin
        queue_byte($urandom_range(1) ? BYTE_CSI : BYTE_SS3);
        if ($urandom_range(1)) queue_byte(rand_digit());
      end
      queue_tick();
    end else if (pick < 95) begin
      queue_tick();
      counted = 0;
      flush_seq();
      return;
    end else begin
      queue_esc_seq(BYTE_CSI, ByteW'($urandom_range(255)));
    end
    counted = seq_q.size();
    flush_seq();
  endtask

  task automatic run_random(input int n_items);
    int done;
    int cnt;
    done = 0;
    while (done < n_items) begin
      make_random_key(cnt);
      done += cnt;
    end
  endtask

  // pause the sender until every expected key is back and the pipe is empty
  task automatic drain_keys();
    in_valid <= 1'b0;
    @(posedge clk);
    while (keys_waiting != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_screen(input int rows, input int cols);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SCREEN_ROWS;
    cfg_data <= PosW'(rows);
    @(posedge clk);
    cfg_idx  <= CFG_SCREEN_COLS;
    cfg_data <= PosW'(cols);
    @(posedge clk);
    cfg_we   <= 1'b0;
    sizes_used++;
  endtask

  task automatic run_directed();
    queue_byte(8'h00);                      // lowest plain byte
    queue_byte(8'hff);                      // highest plain byte
    queue_byte(BYTE_QUIT);                  // ctrl-q raises quit only
    queue_tick();                           // tick while idle gives nothing
    queue_esc_seq(BYTE_CSI, LTR_DOWN);      // arrow
    queue_esc_seq(BYTE_SS3, LTR_END);       // end through the ss3 form
    queue_esc_seq(BYTE_CSI, 8'h36);         // page down, '6'
    queue_byte(BYTE_TILDE);
    queue_esc_seq(BYTE_CSI, 8'h32);         // '2' is not a known digit
    queue_byte(BYTE_TILDE);
    queue_byte(BYTE_ESC);                   // timeout right after esc
    queue_tick();
    queue_esc_seq(LTR_JUNK, LTR_JUNK);      // unknown second byte
    flush_seq();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    snd_idle_pct = 32;
    rcv_idle_pct = 86;
    run_directed();
    run_random(ItemsPerPhase);
    drain_keys();

    // biggest screen, lets end and page down push the cursor far out
    write_screen(1023, 1023);
    run_random(ItemsPerPhase);
    drain_keys();

    // shrink under the cursor, it must stay put until moved back in
    write_screen(3, 5);
    run_random(ItemsPerPhase);
    drain_keys();

    // roles swapped
    snd_idle_pct = 86;
    rcv_idle_pct = 32;
    write_screen(1, 1);
    run_random(ItemsPerPhase);
    drain_keys();

    write_screen($urandom_range(40, 1), $urandom_range(40, 1));
    run_random(ItemsPerPhase / 2);
    drain_keys();
    run_random(ItemsPerPhase / 2);
    drain_keys();

    // full rate, with one long hold-off so the pipe fills and stalls input
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_screen($urandom_range(1023, 1), $urandom_range(1023, 1));
    run_random(ItemsPerPhase / 4);
    hold_reqs <= hold_reqs + 1;
    run_random(ItemsPerPhase - ItemsPerPhase / 4);
    drain_keys();

    write_screen(1023, 1);
    run_random(ItemsPerPhase);
    drain_keys();

    $display("ran %0d input transfers and checked %0d keys across %0d screen sizes",
             xfers_sent, keys_checked, sizes_used);
    $display("idle mixes: light/heavy, heavy/light, none; one long result-side hold-off");
    if (err_cnt == 0 && keys_waiting == 0) begin
      $display("escape_key_decoder_cursor_tb: clean");
    end else begin
      $display("escape_key_decoder_cursor_tb: errors");
    end
    $finish;
  end

endmodule
